FILE: sv/histogram_equalize_clipped_assert.svh
// Assertion macros for the clipped histogram equalizer.
// Used by the top level; expects clk and rst in the including scope.
`ifndef HISTOGRAM_EQUALIZE_CLIPPED_ASSERT_SVH
`define HISTOGRAM_EQUALIZE_CLIPPED_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a consequent in the same cycle as its antecedent
`define HEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Check a consequent in the cycle after its antecedent
`define HEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HEC_ASSERT_NOW(lbl, ante, cons, msg)
`define HEC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/hec_pkg.sv
// Shared types and constants for the clipped histogram equalizer.
// No dependencies; used by hec_level_table, histogram_equalize_clipped and tb_top.
package hec_pkg;

  localparam int PIX_W    = 12;
  localparam int DEPTH    = 1 << PIX_W;
  localparam int IDX_W    = PIX_W + 1;
  localparam int CNT_W    = 32;
  localparam int LVL_W    = 8;
  localparam int RUN_W    = CNT_W + PIX_W;
  localparam int ACC_W    = RUN_W + LVL_W;
  localparam int FRAC_W   = 16;
  localparam int LCNT_W   = 9;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam int REG_SEL_BIT = 2;

  localparam logic [PIX_W-1:0]  MAX_VALUE  = PIX_W'(4095);
  localparam logic [PIX_W-1:0]  LAST_IDX   = PIX_W'(DEPTH - 1);
  localparam logic [FRAC_W-1:0] FRAC_MAX   = 16'd32768;
  localparam logic [LCNT_W-1:0] LEVELS_MAX = 9'd256;
  localparam logic [LCNT_W-1:0] LEVELS_MIN = 9'd1;

  // Register index codes
  localparam logic REG_FRACTION = 1'b0;
  localparam logic REG_LEVELS   = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ACC   = 2'd1,
    OP_BUILD = 2'd2,
    OP_MAP   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC_WR,
    ST_CUT,
    ST_SCAN_LO,
    ST_SCAN_HI,
    ST_SPAN,
    ST_FILL_RD,
    ST_FILL_ADD,
    ST_FILL_STEP
  } state_t;

  // Level table write request
  typedef struct packed {
    logic             en;
    logic [PIX_W-1:0] addr;
    logic [LVL_W-1:0] data;
  } tbl_wr_t;

  // Clamp the level count to 1..256 and return the top level
  function automatic logic [LVL_W-1:0] level_top(input logic [LCNT_W-1:0] lcnt);
    logic [LCNT_W-1:0] c;
    if (lcnt < LEVELS_MIN) c = LEVELS_MIN;
    else if (lcnt > LEVELS_MAX) c = LEVELS_MAX;
    else c = lcnt;
    return LVL_W'(c - LEVELS_MIN);
  endfunction

endpackage

FILE: sv/histogram_equalize_clipped.sv
// Top level of the clipped histogram equalizer: histogram memory, build sequencer, APB registers.
// Depends on hec_pkg, hec_level_table and histogram_equalize_clipped_assert.svh.
//
// Ops on the input channel: clear, accumulate, build, map. After reset and after each clear
// the block runs a clearing pass over the 4096-entry histogram memory and takes no item
// meanwhile; APB writes are taken at any time. Accumulate is a read-modify-write of the
// histogram port: the read in the accepting cycle, the write in ST_ACC_WR. Map returns its
// level in the next cycle; maps can follow each other every cycle while the output is drained.
// Build runs a sequencer over the histogram port: ST_CUT forms the cut, then three walks over
// the seen pixel range (low cut, high cut, span, one entry a cycle each, stopping early at the
// cuts; an empty frame skips them), then ST_FILL_RD starts the fill, each table entry passes
// ST_FILL_ADD and ST_FILL_STEP, and each output level step (at most 255) adds an ST_FILL_STEP
// pass. Configuration is meant to be written while the block is idle.
`include "histogram_equalize_clipped_assert.svh"
module histogram_equalize_clipped (
  input  logic                        clk,
  input  logic                        rst,
  // Item input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  op,
  input  logic [hec_pkg::PIX_W-1:0]   pixel,
  // Result output
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hec_pkg::LVL_W-1:0]   level,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hec_pkg::ADDR_W-1:0]  paddr,
  input  logic [hec_pkg::DATA_W-1:0]  pwdata,
  output logic [hec_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  hec_pkg::state_t state, state_next;

  // Configuration and frame statistics
  logic [hec_pkg::FRAC_W-1:0] frac_reg;
  logic [hec_pkg::LCNT_W-1:0] lcnt_reg;
  logic [hec_pkg::PIX_W-1:0]  min_seen;
  logic [hec_pkg::PIX_W-1:0]  max_seen;
  logic [hec_pkg::CNT_W-1:0]  pixel_total;

  // Histogram memory ports
  logic [hec_pkg::CNT_W-1:0]  hist_mem [hec_pkg::DEPTH];
  logic [hec_pkg::CNT_W-1:0]  hist_rd;
  logic [hec_pkg::PIX_W-1:0]  hist_raddr;
  logic                       hist_we;
  logic [hec_pkg::PIX_W-1:0]  hist_waddr;
  logic [hec_pkg::CNT_W-1:0]  hist_wdata;

  // Sequencer registers
  logic [hec_pkg::PIX_W-1:0]  pix_reg;
  logic [hec_pkg::PIX_W-1:0]  clr_idx;
  logic [hec_pkg::CNT_W-1:0]  cut;
  logic [hec_pkg::LVL_W-1:0]  top_lvl;
  logic                       empty;
  logic [hec_pkg::IDX_W-1:0]  idx;
  logic                       rv;
  logic [hec_pkg::PIX_W-1:0]  ridx;
  logic [hec_pkg::RUN_W-1:0]  run;
  logic [hec_pkg::PIX_W-1:0]  lo;
  logic [hec_pkg::PIX_W-1:0]  hi;
  logic [hec_pkg::RUN_W-1:0]  span;
  logic [hec_pkg::PIX_W-1:0]  fidx;
  logic [hec_pkg::ACC_W-1:0]  acc;
  logic [hec_pkg::ACC_W-1:0]  thresh;
  logic [hec_pkg::LVL_W-1:0]  fill_q;

  // Combinational helpers
  logic                                  accept;
  logic                                  map_free;
  logic                                  map_rd_en;
  logic                                  cfg_we;
  logic [hec_pkg::FRAC_W-1:0]            frac_eff;
  logic [hec_pkg::CNT_W+hec_pkg::FRAC_W-1:0] cut_prod;
  logic                                  scan_issue;
  logic [hec_pkg::RUN_W-1:0]             run_sum;
  logic                                  hit;
  logic                                  scan_done;
  logic                                  fill_mid;
  logic                                  fill_step;
  logic [hec_pkg::LVL_W-1:0]             fill_level;
  logic [hec_pkg::CNT_W+hec_pkg::LVL_W-1:0] acc_add;
  logic [hec_pkg::CNT_W-1:0]             hist_inc;
  hec_pkg::tbl_wr_t                      tbl_wr;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == hec_pkg::ST_IDLE) && ((op != hec_pkg::OP_MAP) || map_free);
  assign map_rd_en = accept && (op == hec_pkg::OP_MAP);

  // Cut count and fill arithmetic
  assign frac_eff = (frac_reg > hec_pkg::FRAC_MAX) ? hec_pkg::FRAC_MAX : frac_reg;
  assign cut_prod = (hec_pkg::CNT_W+hec_pkg::FRAC_W)'(pixel_total)
                  * (hec_pkg::CNT_W+hec_pkg::FRAC_W)'(frac_eff);
  assign run_sum  = run + hec_pkg::RUN_W'(hist_rd);
  assign hit      = rv && (run_sum >= hec_pkg::RUN_W'(cut));
  assign scan_done = !scan_issue && !rv;
  assign acc_add  = (hec_pkg::CNT_W+hec_pkg::LVL_W)'(hist_rd)
                  * (hec_pkg::CNT_W+hec_pkg::LVL_W)'(top_lvl);
  assign hist_inc = (hist_rd == '1) ? hist_rd : hist_rd + 32'd1;

  assign fill_mid  = !empty && (fidx >= lo) && (fidx < hi) && (span != '0);
  assign fill_step = fill_mid && (acc >= thresh);

  // Pick the table entry for the current fill index
  always_comb begin
    if (empty || (fidx < lo)) begin
      fill_level = '0;
    end else if (fidx >= hi) begin
      fill_level = top_lvl;
    end else if (fill_mid) begin
      fill_level = fill_q;
    end else begin
      fill_level = '0;
    end
  end

  // Walk bound for the active scan
  always_comb begin
    unique case (state)
      hec_pkg::ST_SCAN_LO: scan_issue = idx <= {1'b0, max_seen};
      hec_pkg::ST_SCAN_HI: scan_issue = idx > {1'b0, min_seen};
      hec_pkg::ST_SPAN:    scan_issue = idx <= {1'b0, hi};
      default:             scan_issue = 1'b0;
    endcase
  end

  // Next state and memory controls
  always_comb begin
    state_next = state;
    hist_raddr = idx[hec_pkg::PIX_W-1:0];
    hist_we    = 1'b0;
    hist_waddr = clr_idx;
    hist_wdata = '0;
    tbl_wr     = '0;
    unique case (state)
      hec_pkg::ST_CLEAR: begin
        hist_we = 1'b1;
        if (clr_idx == hec_pkg::LAST_IDX) state_next = hec_pkg::ST_IDLE;
      end
      hec_pkg::ST_IDLE: begin
        hist_raddr = pixel;
        if (accept) begin
          unique case (hec_pkg::op_t'(op))
            hec_pkg::OP_CLEAR: state_next = hec_pkg::ST_CLEAR;
            hec_pkg::OP_ACC: begin
              if (pixel <= hec_pkg::MAX_VALUE) state_next = hec_pkg::ST_ACC_WR;
            end
            hec_pkg::OP_BUILD: state_next = hec_pkg::ST_CUT;
            hec_pkg::OP_MAP:   state_next = hec_pkg::ST_IDLE;
            default:           state_next = hec_pkg::ST_IDLE;
          endcase
        end
      end
      hec_pkg::ST_ACC_WR: begin
        hist_we    = 1'b1;
        hist_waddr = pix_reg;
        hist_wdata = hist_inc;
        state_next = hec_pkg::ST_IDLE;
      end
      hec_pkg::ST_CUT: begin
        state_next = (pixel_total == '0) ? hec_pkg::ST_FILL_RD : hec_pkg::ST_SCAN_LO;
      end
      hec_pkg::ST_SCAN_LO: begin
        if (hit || scan_done) state_next = hec_pkg::ST_SCAN_HI;
      end
      hec_pkg::ST_SCAN_HI: begin
        if (hit || scan_done) state_next = hec_pkg::ST_SPAN;
      end
      hec_pkg::ST_SPAN: begin
        if (scan_done) state_next = hec_pkg::ST_FILL_RD;
      end
      hec_pkg::ST_FILL_RD: begin
        hist_raddr = fidx;
        state_next = hec_pkg::ST_FILL_ADD;
      end
      hec_pkg::ST_FILL_ADD: begin
        state_next = hec_pkg::ST_FILL_STEP;
      end
      hec_pkg::ST_FILL_STEP: begin
        hist_raddr = fidx + 12'd1;
        if (!fill_step) begin
          tbl_wr.en   = 1'b1;
          tbl_wr.addr = fidx;
          tbl_wr.data = fill_level;
          state_next  = (fidx == hec_pkg::LAST_IDX) ? hec_pkg::ST_IDLE : hec_pkg::ST_FILL_ADD;
        end
      end
      default: state_next = hec_pkg::ST_IDLE;
    endcase
  end

  // State register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hec_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Histogram memory
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rd <= hist_mem[hist_raddr];
  end

  // Configuration registers
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_reg <= '0;
      lcnt_reg <= hec_pkg::LEVELS_MAX;
    end else if (cfg_we) begin
      unique case (paddr[hec_pkg::REG_SEL_BIT])
        hec_pkg::REG_FRACTION: frac_reg <= pwdata[hec_pkg::FRAC_W-1:0];
        hec_pkg::REG_LEVELS:   lcnt_reg <= pwdata[hec_pkg::LCNT_W-1:0];
        default:               frac_reg <= frac_reg;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[hec_pkg::REG_SEL_BIT])
      hec_pkg::REG_FRACTION: prdata = hec_pkg::DATA_W'(frac_reg);
      hec_pkg::REG_LEVELS:   prdata = hec_pkg::DATA_W'(lcnt_reg);
      default:               prdata = '0;
    endcase
  end

  // Frame statistics and clear index
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx     <= '0;
      min_seen    <= '1;
      max_seen    <= '0;
      pixel_total <= '0;
    end else if (state == hec_pkg::ST_CLEAR) begin
      clr_idx <= clr_idx + 12'd1;
    end else if (accept && (op == hec_pkg::OP_CLEAR)) begin
      clr_idx     <= '0;
      min_seen    <= '1;
      max_seen    <= '0;
      pixel_total <= '0;
    end else if (accept && (op == hec_pkg::OP_ACC) && (pixel <= hec_pkg::MAX_VALUE)) begin
      if (pixel_total != '1) pixel_total <= pixel_total + 32'd1;
      if (pixel < min_seen) min_seen <= pixel;
      if (pixel > max_seen) max_seen <= pixel;
    end
  end

  // Scan valid flag; the cut walks stop issuing on a hit, the span walk never does
  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else if ((state == hec_pkg::ST_SCAN_LO) || (state == hec_pkg::ST_SCAN_HI)) begin
      rv <= scan_issue && !hit;
    end else if (state == hec_pkg::ST_SPAN) begin
      rv <= scan_issue;
    end else begin
      rv <= 1'b0;
    end
  end

  // Build datapath: cut, scans, span and incremental level fill
  always_ff @(posedge clk) begin
    if (accept && (op == hec_pkg::OP_ACC)) begin
      pix_reg <= pixel;
    end
    unique case (state)
      hec_pkg::ST_CUT: begin
        cut     <= cut_prod[hec_pkg::CNT_W+hec_pkg::FRAC_W-1:hec_pkg::FRAC_W] + 32'd1;
        top_lvl <= hec_pkg::level_top(lcnt_reg);
        empty   <= (pixel_total == '0);
        idx     <= {1'b0, min_seen} + 13'd1;
        run     <= '0;
        span    <= '0;
        fidx    <= '0;
        acc     <= '0;
        fill_q  <= '0;
      end
      hec_pkg::ST_SCAN_LO: begin
        ridx <= idx[hec_pkg::PIX_W-1:0];
        if (hit || scan_done) begin
          lo  <= hit ? ridx : min_seen;
          idx <= {1'b0, max_seen};
          run <= '0;
        end else begin
          if (scan_issue) idx <= idx + 13'd1;
          if (rv) run <= run_sum;
        end
      end
      hec_pkg::ST_SCAN_HI: begin
        ridx <= idx[hec_pkg::PIX_W-1:0];
        if (hit || scan_done) begin
          hi  <= hit ? ridx : max_seen;
          idx <= {1'b0, lo};
          run <= '0;
        end else begin
          if (scan_issue) idx <= idx - 13'd1;
          if (rv) run <= run_sum;
        end
      end
      hec_pkg::ST_SPAN: begin
        ridx <= idx[hec_pkg::PIX_W-1:0];
        if (scan_issue) idx <= idx + 13'd1;
        if (rv) run <= run_sum;
        if (scan_done) begin
          span   <= run;
          thresh <= hec_pkg::ACC_W'(run);
        end
      end
      hec_pkg::ST_FILL_ADD: begin
        if (fidx >= lo) acc <= acc + hec_pkg::ACC_W'(acc_add);
      end
      hec_pkg::ST_FILL_STEP: begin
        // Advance the level while the cumulative count passes the next threshold
        if (fill_step) begin
          fill_q <= fill_q + 8'd1;
          thresh <= thresh + hec_pkg::ACC_W'(span);
        end else begin
          fidx <= fidx + 12'd1;
        end
      end
      default: begin
        fidx <= fidx;
      end
    endcase
  end

  hec_level_table u_table (
    .clk       (clk),
    .rst       (rst),
    .wr        (tbl_wr),
    .rd_en     (map_rd_en),
    .rd_addr   (pixel),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .level     (level),
    .map_free  (map_free)
  );

  // Checks
  `HEC_ASSERT_NEXT(a_map_result, accept && (op == hec_pkg::OP_MAP), out_valid, "map item gave no result")
  `HEC_ASSERT_NEXT(a_acc_write, accept && (op == hec_pkg::OP_ACC), hist_we, "accumulate missed its write")
  `HEC_ASSERT_NOW(a_level_bound, state == hec_pkg::ST_FILL_STEP, fill_q <= top_lvl, "level above top")

endmodule

FILE: sv/hec_level_table.sv
// Level table memory with its registered read port serving as the result register.
// Depends on hec_pkg for widths and the write request type.
module hec_level_table (
  input  logic                       clk,
  input  logic                       rst,
  input  hec_pkg::tbl_wr_t           wr,
  input  logic                       rd_en,
  input  logic [hec_pkg::PIX_W-1:0]  rd_addr,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [hec_pkg::LVL_W-1:0]  level,
  output logic                       map_free
);

  logic [hec_pkg::LVL_W-1:0] tbl_mem [hec_pkg::DEPTH];
  logic [hec_pkg::LVL_W-1:0] rd_data;

  // Write fill entries; read a mapped pixel and hold the level until the next read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      tbl_mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= tbl_mem[rd_addr];
    end
  end

  // Raise valid with each read, drop it when the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign level    = rd_data;
  assign map_free = !out_valid || out_ready;

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for histogram_equalize_clipped: item stream, result stream, APB registers.
// Depends on hec_pkg and the histogram_equalize_clipped RTL; predicts levels with its own
// histogram, cut search and level table, and checks every returned level in order.
module tb_top;

  localparam int     BUILD_CYCLES = 21000;    // longest build walk plus margin
  localparam int     TAIL_CYCLES  = 50;
  localparam longint CYCLE_LIMIT  = 8_000_000;
  localparam int     PHASES       = 8;
  localparam int     PHASE_ITEMS  = 160;
  localparam int     STEPS        = 24;

  localparam logic [hec_pkg::ADDR_W-1:0] FRACTION_ADDR = {hec_pkg::REG_FRACTION, 2'b00};
  localparam logic [hec_pkg::ADDR_W-1:0] LEVELS_ADDR   = {hec_pkg::REG_LEVELS, 2'b00};

  // Pixel mixes used to build random frames
  typedef enum int {BAND, SPREAD, BACKDROP, EXTREMES} frame_kind_t;

  typedef struct packed {
    hec_pkg::op_t              code;
    logic [hec_pkg::PIX_W-1:0] px;
    logic                      fixed;
    logic [hec_pkg::LVL_W-1:0] lvl;
  } step_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic [1:0]                   op;
  logic [hec_pkg::PIX_W-1:0]    pixel;
  logic                         out_valid;
  logic                         out_ready;
  logic [hec_pkg::LVL_W-1:0]    level;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [hec_pkg::ADDR_W-1:0]   paddr;
  logic [hec_pkg::DATA_W-1:0]   pwdata;
  logic [hec_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  // Predicted frame state and level table
  logic [31:0]                  hist_bins [hec_pkg::DEPTH];
  logic [hec_pkg::LVL_W-1:0]    lvl_lut [hec_pkg::DEPTH];
  logic [hec_pkg::PIX_W-1:0]    frame_min;
  logic [hec_pkg::PIX_W-1:0]    frame_max;
  logic [31:0]                  frame_count;
  logic [hec_pkg::FRAC_W-1:0]   clip_frac;
  logic [hec_pkg::LCNT_W-1:0]   level_cnt;

  logic [hec_pkg::LVL_W-1:0]    pending_levels [$];
  logic [hec_pkg::LVL_W-1:0]    want_level;
  int                           fault_count;
  int                           items_sent;
  int                           builds_sent;
  int                           levels_seen;
  int                           settings_used;
  int                           in_quiet;
  int                           out_quiet;
  longint                       cycle_count;

  // Directed walk: empty frame, extremes, background skip, clear keeps table, single value
  step_t directed_steps [STEPS] = '{
    '{hec_pkg::OP_BUILD, 12'd0,    1'b0, 8'd0},
    '{hec_pkg::OP_MAP,   12'd0,    1'b1, 8'd0},
    '{hec_pkg::OP_MAP,   12'd4095, 1'b1, 8'd0},
    '{hec_pkg::OP_MAP,   12'd2730, 1'b1, 8'd0},
    '{hec_pkg::OP_ACC,   12'd0,    1'b0, 8'd0},
    '{hec_pkg::OP_ACC,   12'd4095, 1'b0, 8'd0},
    '{hec_pkg::OP_ACC,   12'd100,  1'b0, 8'd0},
    '{hec_pkg::OP_ACC,   12'd100,  1'b0, 8'd0},
    '{hec_pkg::OP_ACC,   12'd2000, 1'b0, 8'd0},
    '{hec_pkg::OP_ACC,   12'd1365, 1'b0, 8'd0},
    '{hec_pkg::OP_BUILD, 12'd0,    1'b0, 8'd0},
    '{hec_pkg::OP_MAP,   12'd0,    1'b1, 8'd0},
    '{hec_pkg::OP_MAP,   12'd4095, 1'b1, 8'd255},
    '{hec_pkg::OP_MAP,   12'd100,  1'b0, 8'd0},
    '{hec_pkg::OP_MAP,   12'd1365, 1'b0, 8'd0},
    '{hec_pkg::OP_MAP,   12'd2000, 1'b0, 8'd0},
    '{hec_pkg::OP_MAP,   12'd50,   1'b1, 8'd0},
    '{hec_pkg::OP_CLEAR, 12'd0,    1'b0, 8'd0},
    '{hec_pkg::OP_MAP,   12'd2000, 1'b0, 8'd0},
    '{hec_pkg::OP_ACC,   12'd7,    1'b0, 8'd0},
    '{hec_pkg::OP_BUILD, 12'd0,    1'b0, 8'd0},
    '{hec_pkg::OP_MAP,   12'd7,    1'b1, 8'd255},
    '{hec_pkg::OP_MAP,   12'd6,    1'b1, 8'd0},
    '{hec_pkg::OP_MAP,   12'd4095, 1'b1, 8'd255}
  };

  histogram_equalize_clipped dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .level     (level),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count a mismatch; report only the first few
  function automatic void note_fault(string what, longint expv, longint gotv);
    if (fault_count < 10) $display("MISMATCH %s: expected %0d, got %0d", what, expv, gotv);
    fault_count++;
  endfunction

  // Queue one expected level at the back
  function automatic void queue_level(logic [hec_pkg::LVL_W-1:0] lvl);
    pending_levels = {pending_levels, lvl};
  endfunction

  // Pick an idle length: mostly zero or short, a few long, with quiet stretches
  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet = $urandom_range(40, 200);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Empty the histogram and the frame statistics
  function automatic void wipe_frame();
    foreach (hist_bins[i]) hist_bins[i] = '0;
    frame_min   = '1;
    frame_max   = '0;
    frame_count = '0;
  endfunction

  // Count one pixel, saturating the counts
  function automatic void tally_pixel(logic [hec_pkg::PIX_W-1:0] px);
    if (px > hec_pkg::MAX_VALUE) return;
    if (hist_bins[px] != '1) hist_bins[px]++;
    if (frame_count != '1) frame_count++;
    if (px < frame_min) frame_min = px;
    if (px > frame_max) frame_max = px;
  endfunction

  // Find the cuts and refill the level table from the clipped cumulative histogram
  function automatic void rebuild_lut();
    int                         lo;
    int                         hi;
    longint unsigned            top;
    longint unsigned            cut;
    longint unsigned            run;
    longint unsigned            span;
    logic [hec_pkg::FRAC_W-1:0] frac;
    if (frame_count == 0) begin
      foreach (lvl_lut[j]) lvl_lut[j] = '0;
      return;
    end
    if (level_cnt == 0) top = 0;
    else if (level_cnt > 256) top = 255;
    else top = level_cnt - 1;
    frac = (clip_frac > 16'd32768) ? 16'd32768 : clip_frac;
    cut  = ((64'(frame_count) * 64'(frac)) >> 16) + 1;

    // Skip the background value, then walk up to the low cut
    lo  = frame_min;
    run = 0;
    for (int i = int'(frame_min) + 1; i <= int'(frame_max); i++) begin
      run += hist_bins[i];
      if (run >= cut) begin
        lo = i;
        break;
      end
    end

    // Walk down from the top to the high cut
    hi  = frame_max;
    run = 0;
    for (int i = int'(frame_max); i > int'(frame_min); i--) begin
      run += hist_bins[i];
      if (run >= cut) begin
        hi = i;
        break;
      end
    end

    span = 0;
    for (int i = lo; i <= hi && i < hec_pkg::DEPTH; i++) span += hist_bins[i];

    run = 0;
    for (int i = 0; i < hec_pkg::DEPTH; i++) begin
      if (i >= lo) run += hist_bins[i];
      if (i < lo) lvl_lut[i] = '0;
      else if (i >= hi) lvl_lut[i] = hec_pkg::LVL_W'(top);
      else if (span == 0) lvl_lut[i] = '0;
      else lvl_lut[i] = hec_pkg::LVL_W'((run * top) / span);
    end
  endfunction

  // Offer one item, hold it until taken, then update the prediction
  task automatic send_item(hec_pkg::op_t code, logic [hec_pkg::PIX_W-1:0] px, logic fixed,
                           logic [hec_pkg::LVL_W-1:0] lvl);
    int gap;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= code;
    pixel    <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    case (code)
      hec_pkg::OP_CLEAR: wipe_frame();
      hec_pkg::OP_ACC:   tally_pixel(px);
      hec_pkg::OP_BUILD: begin
        rebuild_lut();
        builds_sent++;
      end
      default:  queue_level(fixed ? lvl : lvl_lut[px]);
    endcase
  endtask

  // One APB transfer: setup phase, access phase, then an idle phase with psel low
  task automatic apb_access(logic wr, logic [hec_pkg::ADDR_W-1:0] addr,
                            logic [hec_pkg::DATA_W-1:0] wdata,
                            output logic [hec_pkg::DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(logic [hec_pkg::ADDR_W-1:0] addr,
                                logic [hec_pkg::DATA_W-1:0] want);
    logic [hec_pkg::DATA_W-1:0] got;
    apb_access(1'b0, addr, '0, got);
    if (got !== want) note_fault("register readback", want, got);
  endtask

  // Drain results, let any build finish, then load a new setting
  task automatic settle_then_configure(logic [hec_pkg::FRAC_W-1:0] frac,
                                       logic [hec_pkg::LCNT_W-1:0] lcnt);
    logic [hec_pkg::DATA_W-1:0] unused;
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (BUILD_CYCLES) @(posedge clk);
    apb_access(1'b1, FRACTION_ADDR, hec_pkg::DATA_W'(frac), unused);
    clip_frac = frac;
    check_register(FRACTION_ADDR, hec_pkg::DATA_W'(frac));
    apb_access(1'b1, LEVELS_ADDR, hec_pkg::DATA_W'(lcnt), unused);
    level_cnt = lcnt;
    check_register(LEVELS_ADDR, hec_pkg::DATA_W'(lcnt));
    settings_used++;
  endtask

  function automatic logic [hec_pkg::PIX_W-1:0] frame_pixel(frame_kind_t kind, int base,
                                                           int width);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return hec_pkg::PIX_W'($urandom);
    case (kind)
      BAND:     return hec_pkg::PIX_W'(base + $urandom_range(0, width));
      SPREAD:   return hec_pkg::PIX_W'($urandom);
      BACKDROP: return (r < 50) ? hec_pkg::PIX_W'(base)
                                : hec_pkg::PIX_W'(base + $urandom_range(0, width));
      default:  return (r < 45) ? '0 : ((r < 90) ? '1 : hec_pkg::PIX_W'($urandom));
    endcase
  endfunction

  // One frame: usually clear, accumulate, build, then map; sometimes broken on purpose
  task automatic run_frame();
    frame_kind_t kind;
    int          width;
    int          base;
    int          n_px;
    int          n_map;
    kind  = frame_kind_t'($urandom_range(0, 3));
    width = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 1024) : $urandom_range(0, 63);
    base  = $urandom_range(0, 4095 - width);
    if ($urandom_range(0, 7) != 0)
      send_item(hec_pkg::OP_CLEAR, hec_pkg::PIX_W'($urandom), 1'b0, '0);
    n_px = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(8, 120);
    for (int k = 0; k < n_px; k++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(hec_pkg::OP_MAP, hec_pkg::PIX_W'($urandom), 1'b0, '0);
      send_item(hec_pkg::OP_ACC, frame_pixel(kind, base, width), 1'b0, '0);
    end
    if ($urandom_range(0, 9) != 0)
      send_item(hec_pkg::OP_BUILD, hec_pkg::PIX_W'($urandom), 1'b0, '0);
    n_map = $urandom_range(8, 60);
    for (int k = 0; k < n_map; k++) begin
      if ($urandom_range(0, 4) < 3)
        send_item(hec_pkg::OP_MAP, frame_pixel(kind, base, width), 1'b0, '0);
      else send_item(hec_pkg::OP_MAP, hec_pkg::PIX_W'($urandom), 1'b0, '0);
    end
  endtask

  // Main sequence
  initial begin
    int unsigned frac_plan [PHASES];
    int unsigned lcnt_plan [PHASES];
    int          phase_start;
    rst       = 1'b1;
    in_valid  = 1'b0;
    op        = hec_pkg::OP_CLEAR;
    pixel     = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    fault_count   = 0;
    items_sent    = 0;
    builds_sent   = 0;
    levels_seen   = 0;
    settings_used = 1;
    in_quiet      = 0;
    wipe_frame();
    foreach (lvl_lut[i]) lvl_lut[i] = '0;
    clip_frac = '0;
    level_cnt = hec_pkg::LEVELS_MAX;

    frac_plan = '{32768, 65535, 0, 6554, 1, 0, 0, 0};
    lcnt_plan = '{1, 511, 0, 256, 2, 0, 0, 0};
    for (int p = 5; p < PHASES; p++) begin
      frac_plan[p] = $urandom_range(0, 65535);
      lcnt_plan[p] = $urandom_range(0, 511);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers come up at their reset values
    check_register(FRACTION_ADDR, '0);
    check_register(LEVELS_ADDR, hec_pkg::DATA_W'(hec_pkg::LEVELS_MAX));

    foreach (directed_steps[s])
      send_item(directed_steps[s].code, directed_steps[s].px, directed_steps[s].fixed,
                directed_steps[s].lvl);

    for (int p = 0; p < PHASES; p++) begin
      settle_then_configure(hec_pkg::FRAC_W'(frac_plan[p]), hec_pkg::LCNT_W'(lcnt_plan[p]));
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) run_frame();
    end

    // Drain and watch for stray results
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d items including %0d table builds; checked %0d mapped levels.",
             items_sent, builds_sent, levels_seen);
    $display("Covered %0d register settings under random input gaps and output stalls.",
             settings_used);
    if (fault_count == 0) begin
      $display("histogram_equalize_clipped test passed");
    end else begin
      $display("%0d mismatches in total", fault_count);
      $display("histogram_equalize_clipped test failed");
    end
    $finish;
  end

  // Result side: open and stall at random
  initial begin
    int n_open;
    int n_stall;
    out_ready = 1'b0;
    out_quiet = 0;
    @(posedge clk);
    forever begin
      n_open  = $urandom_range(1, 8);
      n_stall = pick_gap(out_quiet);
      out_ready <= 1'b1;
      repeat (n_open) @(posedge clk);
      if (n_stall > 0) begin
        out_ready <= 1'b0;
        repeat (n_stall) @(posedge clk);
      end
    end
  end

  // Compare each returned level with the oldest pending one
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_levels.size() == 0) begin
        note_fault("level with nothing pending", -1, level);
      end else begin
        want_level = pending_levels.pop_front();
        levels_seen++;
        if (level !== want_level) note_fault("level", want_level, level);
      end
    end
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d levels pending", cycle_count,
             pending_levels.size());
    $display("histogram_equalize_clipped test failed");
    $finish;
  end

endmodule
